>>> hdl/spzs_pkg.sv
// spzs_pkg: shared constants, codes and types for the strip pedestal
// subtraction and zero suppression block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package spzs_pkg;

  // Table geometry
  localparam int DETECTORS   = 4;
  localparam int STRIPS      = 1024;
  localparam int TABLE_DEPTH = DETECTORS * STRIPS;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // Field widths
  localparam int DET_W    = 2;
  localparam int STRIP_W  = 10;
  localparam int ADC_W    = 12;
  localparam int PED_W    = 16;
  localparam int SIGMA_W  = 12;
  localparam int GAIN_W   = 8;
  localparam int SSIDE_W  = 11;
  localparam int ENERGY_W = 16;
  localparam int PROD_W   = GAIN_W + SIGMA_W;   // gain * sigma
  localparam int DIFF_W   = PED_W + 2;          // adc*16 - pedestal, signed
  localparam int EN_W     = DIFF_W + 1;         // diff - threshold, signed

  // Item command codes (carried in tuser)
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_HIT  = 1'b1;

  // Configuration register indexes
  localparam logic CFG_NOISE_GAIN = 1'b0;
  localparam logic CFG_S_SIDE     = 1'b1;

  // Reset values of configuration registers
  localparam logic [GAIN_W-1:0]  NOISE_GAIN_RST = GAIN_W'(80);
  localparam logic [SSIDE_W-1:0] S_SIDE_RST     = SSIDE_W'(640);

  // One calibration entry, dead flag on top
  typedef struct packed {
    logic               dead;
    logic [SIGMA_W-1:0] sigma;
    logic [PED_W-1:0]   ped;
  } cal_entry_t;

  // Hit payload that travels with the table read
  typedef struct packed {
    logic [DET_W-1:0]   det;
    logic [STRIP_W-1:0] strip;
    logic [ADC_W-1:0]   adc;
  } hit_t;

  // One result item
  typedef struct packed {
    logic [ENERGY_W-1:0] energy;
    logic [STRIP_W-1:0]  strip_in_side;
    logic                side;
    logic [DET_W-1:0]    det;
  } result_t;

endpackage

`default_nettype wire

>>> hdl/spzs_cal_mem.sv
// spzs_cal_mem: calibration table, one write port and one registered read port.
// Depends on spzs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spzs_cal_mem (
  input  wire                         clk_i,
  input  wire                         we_i,
  input  wire  [spzs_pkg::ADDR_W-1:0] waddr_i,
  input  wire  spzs_pkg::cal_entry_t  wdata_i,
  input  wire                         re_i,
  input  wire  [spzs_pkg::ADDR_W-1:0] raddr_i,
  output spzs_pkg::cal_entry_t        rdata_o
);

  spzs_pkg::cal_entry_t mem_q [spzs_pkg::TABLE_DEPTH];
  spzs_pkg::cal_entry_t rdata_q;

  // Write port; contents undefined until loaded
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hdl/spzs_energy.sv
// spzs_energy: threshold product, pedestal subtraction and zero-suppress stages.
// Depends on spzs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spzs_energy (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire  [spzs_pkg::GAIN_W-1:0]  noise_gain_i,
  input  wire  [spzs_pkg::SSIDE_W-1:0] s_side_strips_i,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire  spzs_pkg::hit_t         hit_i,
  input  wire  spzs_pkg::cal_entry_t   entry_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output spzs_pkg::result_t            result_o
);

  // Stage 2 registers
  logic                                  v2_q;
  logic [spzs_pkg::PROD_W-1:0]           prod_q, prod_d;
  logic signed [spzs_pkg::DIFF_W-1:0]    diff_q, diff_d;
  logic                                  dead_q;
  logic [spzs_pkg::DET_W-1:0]            det_q;
  logic                                  side_q, side_d;
  logic [spzs_pkg::STRIP_W-1:0]          local_q, local_d;

  // Stage 3 (output) registers
  logic                                  v3_q;
  spzs_pkg::result_t                     res_q;

  logic                                  ready2;
  logic                                  ready3;
  logic [spzs_pkg::PROD_W-1:0]           thr_sum;
  logic [spzs_pkg::ENERGY_W-1:0]         thr;
  logic signed [spzs_pkg::EN_W-1:0]      energy;
  logic                                  keep;

  // Per-stage flow control: a stage loads when empty or when it moves on
  assign ready3     = !v3_q || out_ready_i;
  assign ready2     = !v2_q || ready3;
  assign in_ready_o = ready2;

  // Stage 2 datapath: gain*sigma, adc*16 - pedestal, side split
  always_comb begin
    prod_d  = spzs_pkg::PROD_W'(noise_gain_i) * spzs_pkg::PROD_W'(entry_i.sigma);
    diff_d  = $signed({2'b00, hit_i.adc, 4'b0000}) - $signed({2'b00, entry_i.ped});
    side_d  = ({1'b0, hit_i.strip} >= s_side_strips_i);
    local_d = side_d ? (hit_i.strip - s_side_strips_i[spzs_pkg::STRIP_W-1:0])
                     : hit_i.strip;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (ready2) begin
      v2_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready2 && in_valid_i) begin
      prod_q  <= prod_d;
      diff_q  <= diff_d;
      dead_q  <= entry_i.dead;
      det_q   <= hit_i.det;
      side_q  <= side_d;
      local_q <= local_d;
    end
  end

  // Stage 3 datapath: round threshold to 1/16 count, subtract, keep if > 0 and not dead
  always_comb begin
    thr_sum = prod_q + spzs_pkg::PROD_W'(8);
    thr     = thr_sum[spzs_pkg::PROD_W-1:4];
    energy  = spzs_pkg::EN_W'(diff_q)
            - $signed({{(spzs_pkg::EN_W-spzs_pkg::ENERGY_W){1'b0}}, thr});
    keep    = !dead_q && !energy[spzs_pkg::EN_W-1] && (energy != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (ready3) begin
      v3_q <= v2_q && keep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready3 && v2_q && keep) begin
      res_q.energy        <= energy[spzs_pkg::ENERGY_W-1:0];
      res_q.strip_in_side <= local_q;
      res_q.side          <= side_q;
      res_q.det           <= det_q;
    end
  end

  assign out_valid_o = v3_q;
  assign result_o    = res_q;

endmodule

`default_nettype wire

>>> hdl/strip_pedestal_zero_suppress.sv
// Strip pedestal subtraction and zero suppression, top level.
// Three register stages: stage 1 with the table read, stages 2 and 3 in spzs_energy.
// Throughput: one item per cycle unless m_axis_tready stalls; the table has one write and one read port.
// Reset clears the stage valid bits and loads the configuration reset values.
// The calibration table is not cleared; the user must load a strip before it is read, the block does not enforce it.
// Depends on spzs_pkg, spzs_cal_mem and spzs_energy.
`timescale 1ns / 1ps
`default_nettype none

module strip_pedestal_zero_suppress (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  // configuration write port
  input  wire                            cfg_we_i,
  input  wire                            cfg_addr_i,
  input  wire  [spzs_pkg::SSIDE_W-1:0]   cfg_wdata_i,
  // input items
  input  wire                            s_axis_tvalid,
  output logic                           s_axis_tready,
  // detector, strip, adc_value, pedestal_load, sigma_load, dead_load, pad
  input  wire  [55:0]                    s_axis_tdata,
  // command
  input  wire                            s_axis_tuser,
  // result items
  output logic                           m_axis_tvalid,
  input  wire                            m_axis_tready,
  // detector_out, side, strip_in_side, energy_out, pad
  output logic [31:0]                    m_axis_tdata
);

  logic [spzs_pkg::GAIN_W-1:0]  noise_gain_q;
  logic [spzs_pkg::SSIDE_W-1:0] s_side_q;

  logic                         accept;
  logic                         in_range;
  logic [spzs_pkg::ADDR_W-1:0]  addr;
  spzs_pkg::hit_t               hit_in;
  spzs_pkg::cal_entry_t         load_entry;
  spzs_pkg::cal_entry_t         rd_entry;
  logic                         mem_we;
  logic                         mem_re;

  // Stage 1 registers (table read is the other half of this stage)
  logic                         v1_q;
  spzs_pkg::hit_t               hit1_q;
  logic                         ready2;

  spzs_pkg::result_t            result;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_gain_q <= spzs_pkg::NOISE_GAIN_RST;
      s_side_q     <= spzs_pkg::S_SIDE_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        spzs_pkg::CFG_NOISE_GAIN: noise_gain_q <= cfg_wdata_i[spzs_pkg::GAIN_W-1:0];
        spzs_pkg::CFG_S_SIDE:     s_side_q     <= cfg_wdata_i;
        default:                  ;
      endcase
    end
  end

  // Input unpacking and table address
  always_comb begin
    hit_in.det       = s_axis_tdata[1:0];
    hit_in.strip     = s_axis_tdata[11:2];
    hit_in.adc       = s_axis_tdata[23:12];
    load_entry.ped   = s_axis_tdata[39:24];
    load_entry.sigma = s_axis_tdata[51:40];
    load_entry.dead  = s_axis_tdata[52];
    in_range = (32'(hit_in.det) < 32'(spzs_pkg::DETECTORS))
            && (32'(hit_in.strip) < 32'(spzs_pkg::STRIPS));
    addr = spzs_pkg::ADDR_W'(hit_in.det) * spzs_pkg::ADDR_W'(spzs_pkg::STRIPS)
         + spzs_pkg::ADDR_W'(hit_in.strip);
  end

  assign s_axis_tready = !v1_q || ready2;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign mem_we        = accept && in_range && (s_axis_tuser == spzs_pkg::CMD_LOAD);
  assign mem_re        = accept && in_range && (s_axis_tuser == spzs_pkg::CMD_HIT);

  spzs_cal_mem u_cal_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (addr),
    .wdata_i (load_entry),
    .re_i    (mem_re),
    .raddr_i (addr),
    .rdata_o (rd_entry)
  );

  // Stage 1: only in-range hits go on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (s_axis_tready) begin
      v1_q <= mem_re;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      hit1_q <= hit_in;
    end
  end

  spzs_energy u_energy (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .noise_gain_i    (noise_gain_q),
    .s_side_strips_i (s_side_q),
    .in_valid_i      (v1_q),
    .in_ready_o      (ready2),
    .hit_i           (hit1_q),
    .entry_i         (rd_entry),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .result_o        (result)
  );

  // Output packing
  assign m_axis_tdata = {3'b000, result.energy, result.strip_in_side, result.side, result.det};

  // A result never carries zero energy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[28:13] != 16'd0))
    else $error("result item with zero energy");

  // A load item never enters the hit pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (s_axis_tuser == spzs_pkg::CMD_LOAD)) |=> !v1_q)
    else $error("load item reached stage 1");

  // A stalled stage 1 keeps its hit and its table entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !ready2) |=> (v1_q && $stable(rd_entry) && $stable(hit1_q)))
    else $error("stage 1 lost its item during a stall");

  // The table is never written and read by the same item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("table written and read in one cycle");

endmodule

`default_nettype wire
